// ===== hw/rtl/amc_pkg.sv =====
// Shared types and constants for the min/max accelerometer calibrator.
`default_nettype none

package amc_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CAL_W    = 28;
    localparam int QUO_W    = 27;
    localparam int OP_W     = 3;
    localparam int AXES     = 3;

    // Scale factor: 1000 means one g
    localparam int CAL_SCALE = 1000;

    // Command codes
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_X_MIN = 3'd1;
    localparam logic [OP_W-1:0] OP_X_MAX = 3'd2;
    localparam logic [OP_W-1:0] OP_Y_MIN = 3'd3;
    localparam logic [OP_W-1:0] OP_Y_MAX = 3'd4;
    localparam logic [OP_W-1:0] OP_Z_MIN = 3'd5;
    localparam logic [OP_W-1:0] OP_Z_MAX = 3'd6;

    // Axis indexes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/accel_minmax_calibrator_unit.sv =====
// Two-point min/max accelerometer calibrator with one shared bit-serial divider.
// Per axis with a non-zero range: a load, one restoring divide step per quotient bit, and a store;
// an axis with a zero range goes from load straight to store. After the Z axis the result is
// written to the output register once the output is free.
// Requests are taken only in idle, after the result has gone to the output register.
// Reset (aresetn low, synchronous) clears all six references to zero and empties the output.
`default_nettype none

module accel_minmax_calibrator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input request
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // sample_x[15:0], sample_y[31:16], sample_z[47:32]
    input  wire logic [2:0]  s_tuser,   // op[2:0]
    // Result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // cal_x[27:0], cal_y[55:28], cal_z[83:56], zero pad
    output logic [2:0]       m_tuser    // err_x[0], err_y[1], err_z[2]
);

    localparam int SW = amc_pkg::SAMPLE_W;
    localparam int QW = amc_pkg::QUO_W;
    localparam int CW = amc_pkg::CAL_W;
    localparam int NA = amc_pkg::AXES;

    amc_pkg::state_t state_reg, state_next;

    logic [1:0]          axis_reg;
    logic [4:0]          cnt_reg;
    logic signed [SW-1:0] samp_reg [NA];
    logic signed [SW-1:0] lo_reg   [NA];
    logic signed [SW-1:0] hi_reg   [NA];
    logic [QW-1:0]       quo_reg;
    logic [SW-1:0]       rem_reg;
    logic [SW-1:0]       dmag_reg;
    logic                neg_reg;
    logic signed [CW-1:0] cal_reg  [NA];
    logic [NA-1:0]       err_reg;
    logic                m_valid_reg;
    logic [87:0]         m_data_reg;
    logic [2:0]          m_user_reg;

    logic                 s_accept;
    logic                 out_load;
    logic signed [SW-1:0] sel_s, sel_lo, sel_hi;
    logic signed [SW:0]   ref_sum, ref_den;
    logic signed [SW+1:0] num_diff;
    logic [SW:0]          num_abs;
    logic [SW-1:0]        den_abs;
    logic                 den_zero;
    logic [QW-1:0]        prod;
    logic [SW:0]          rem_sh;
    logic [SW+1:0]        trial;
    logic signed [CW-1:0] cal_val;

    assign s_tready = (state_reg == amc_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Operand selection and set-up for the current axis
    assign sel_s    = samp_reg[axis_reg];
    assign sel_lo   = lo_reg[axis_reg];
    assign sel_hi   = hi_reg[axis_reg];
    assign ref_sum  = (SW+1)'(sel_hi) + (SW+1)'(sel_lo);
    assign ref_den  = (SW+1)'(sel_hi) - (SW+1)'(sel_lo);
    assign num_diff = ((SW+2)'(sel_s) <<< 1) - (SW+2)'(ref_sum);
    assign num_abs  = num_diff[SW+1] ? (SW+1)'(-num_diff) : (SW+1)'(num_diff);
    assign den_abs  = ref_den[SW] ? SW'(-ref_den) : SW'(ref_den);
    assign den_zero = (ref_den == '0);
    assign prod     = QW'(num_abs) * QW'(amc_pkg::CAL_SCALE);

    // Shared restoring divider step
    assign rem_sh = {rem_reg, quo_reg[QW-1]};
    assign trial  = (SW+2)'(rem_sh) - (SW+2)'(dmag_reg);

    // Sign applied to the quotient magnitude
    assign cal_val = neg_reg ? -CW'(quo_reg) : CW'(quo_reg);

    // Sequencer: next state and output load
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            amc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = amc_pkg::ST_LOAD;
                end
            end
            amc_pkg::ST_LOAD: begin
                state_next = den_zero ? amc_pkg::ST_STORE : amc_pkg::ST_DIV;
            end
            amc_pkg::ST_DIV: begin
                if (cnt_reg == 5'(QW - 1)) begin
                    state_next = amc_pkg::ST_STORE;
                end
            end
            amc_pkg::ST_STORE: begin
                state_next = (axis_reg == amc_pkg::AXIS_Z) ? amc_pkg::ST_DONE
                                                           : amc_pkg::ST_LOAD;
            end
            amc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = amc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = amc_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= amc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Reference capture on request acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NA; i++) begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end else if (s_accept) begin
            case (s_tuser)
                amc_pkg::OP_X_MIN: lo_reg[0] <= s_tdata[15:0];
                amc_pkg::OP_X_MAX: hi_reg[0] <= s_tdata[15:0];
                amc_pkg::OP_Y_MIN: lo_reg[1] <= s_tdata[31:16];
                amc_pkg::OP_Y_MAX: hi_reg[1] <= s_tdata[31:16];
                amc_pkg::OP_Z_MIN: lo_reg[2] <= s_tdata[47:32];
                amc_pkg::OP_Z_MAX: hi_reg[2] <= s_tdata[47:32];
                default: begin
                end
            endcase
        end
    end

    // Datapath: sample capture, per-axis set-up, divide and store
    always_ff @(posedge aclk) begin
        case (state_reg)
            amc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    samp_reg[0] <= s_tdata[15:0];
                    samp_reg[1] <= s_tdata[31:16];
                    samp_reg[2] <= s_tdata[47:32];
                    axis_reg    <= amc_pkg::AXIS_X;
                end
            end
            amc_pkg::ST_LOAD: begin
                quo_reg            <= den_zero ? '0 : prod;
                rem_reg            <= '0;
                dmag_reg           <= den_abs;
                neg_reg            <= num_diff[SW+1] ^ ref_den[SW];
                err_reg[axis_reg]  <= den_zero;
                cnt_reg            <= '0;
            end
            amc_pkg::ST_DIV: begin
                if (!trial[SW+1]) begin
                    rem_reg <= trial[SW-1:0];
                end else begin
                    rem_reg <= rem_sh[SW-1:0];
                end
                quo_reg <= {quo_reg[QW-2:0], ~trial[SW+1]};
                cnt_reg <= cnt_reg + 5'd1;
            end
            amc_pkg::ST_STORE: begin
                cal_reg[axis_reg] <= cal_val;
                axis_reg          <= axis_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    // Output register, parted from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {4'b0000, cal_reg[2], cal_reg[1], cal_reg[0]};
            m_user_reg <= err_reg;
        end
    end

    // Checks
    a_accept_starts_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == amc_pkg::ST_LOAD))
        else $error("accepted request did not start the sequencer");

    a_axis_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == amc_pkg::ST_LOAD || state_reg == amc_pkg::ST_DIV ||
         state_reg == amc_pkg::ST_STORE) |-> (axis_reg != 2'd3))
        else $error("axis index out of range");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == amc_pkg::ST_DIV) |-> (cnt_reg <= 5'(QW - 1)))
        else $error("divider step count overran");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == amc_pkg::ST_DIV) |-> (rem_reg < dmag_reg))
        else $error("partial remainder not below divisor");

    a_err_zero_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[0]) |-> (m_data_reg[27:0] == '0))
        else $error("x error flagged with non-zero result");

endmodule

`default_nettype wire
